FILE: design/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg: shared types and codes of the nested loop item sequencer
// Controller states, command and status bundles, error and function codes.
// ----------------------------------------------------------------------------
`default_nettype none

package nls_pkg;

    // function codes of an input item
    localparam logic FUNC_NEXT  = 1'b0;
    localparam logic FUNC_ENTER = 1'b1;

    // configuration register indexes
    localparam logic CFG_ITEM_COUNT = 1'b0;
    localparam logic CFG_CYCLIC     = 1'b1;

    // error codes of a result item
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DEPTH = 2'd1;
    localparam logic [1:0] ERR_REPS  = 2'd2;

    // item index limits
    localparam logic signed [16:0] TOP_ITEM   = 17'sd65535;
    localparam logic signed [16:0] ITEM_RESET = -17'sd1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the accepted input item
        logic step;    // pop one finished level
        logic commit;  // do the final step and load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic final_step;  // the pending step completes the item
    } t_status;

endpackage

`default_nettype wire

FILE: design/nested_loop_item_sequencer.sv
// An accepted item is captured, P finished levels (0..MAX_LEVELS) are popped one frame
// per cycle, and the final step commits when the output register is free; no new item
// is taken before that commit. A result waits in the output register while the next is taken.
// Reset (synchronous, active low): index before first item, no loops,
// item_count 1, acyclic mode; frame stack contents undefined until pushed.
// ----------------------------------------------------------------------------
// nested_loop_item_sequencer: item index stepper with nested repeat loops
// Controller and datapath joined by command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

module nested_loop_item_sequencer #(
    parameter int MAX_LEVELS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    // input item channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_func,
    input  wire logic [15:0]        i_body_items,
    input  wire logic signed [15:0] i_repetitions,
    input  wire logic [31:0]        i_body_size,
    // result item channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [15:0]             o_item_index,
    output logic [31:0]             o_offset,
    output logic [1:0]              o_error
);
    import nls_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    nls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    nls_datapath #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_body_items  (i_body_items),
        .i_repetitions (i_repetitions),
        .i_body_size   (i_body_size),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_item_index  (o_item_index),
        .o_offset      (o_offset),
        .o_error       (o_error)
    );

endmodule

`default_nettype wire

FILE: design/nls_ctrl.sv
// ----------------------------------------------------------------------------
// nls_ctrl: controller of the nested loop item sequencer
// Accepts an item, pops finished levels one per cycle, then commits the
// final step into the output register when that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire nls_pkg::t_status i_status,
    output nls_pkg::t_cmd         o_cmd
);
    import nls_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_status.final_step) begin
                    o_cmd.step = 1'b1;
                end else if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = o_cmd.commit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    assign o_out_valid = r_out_valid;

    // a committed result is offered in the next cycle
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("committed result not offered");

    // pop and commit never in the same cycle, nor load with either
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.commit && o_cmd.step) && !(o_cmd.load && (o_cmd.step || o_cmd.commit)))
        else $error("conflicting datapath commands");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.commit)
        else $error("result overwritten while stalled");

    // an accepted item starts execution next cycle
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_EXEC))
        else $error("accepted item not executed");

endmodule

`default_nettype wire

FILE: design/nls_datapath.sv
// ----------------------------------------------------------------------------
// nls_datapath: item index, loop frame stack and result register
// Holds the configuration, the captured item, the frame stack and the
// output payload; performs one pop, enter, restart or advance per command.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_datapath #(
    parameter int MAX_LEVELS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    // input item
    input  wire logic               i_func,
    input  wire logic [15:0]        i_body_items,
    input  wire logic signed [15:0] i_repetitions,
    input  wire logic [31:0]        i_body_size,
    // control
    input  wire nls_pkg::t_cmd      i_cmd,
    output nls_pkg::t_status        o_status,
    // result payload
    output logic [15:0]             o_item_index,
    output logic [31:0]             o_offset,
    output logic [1:0]              o_error
);
    import nls_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_LEVELS + 1);
    localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    function automatic logic signed [16:0] bump(input logic signed [16:0] v);
        return (v < TOP_ITEM) ? v + 17'sd1 : TOP_ITEM;
    endfunction

    // configuration and control state
    logic [15:0]         r_item_count;
    logic                r_cyclic;
    logic signed [16:0]  r_cur, n_cur;
    logic [DEPTH_W-1:0]  r_depth, n_depth;

    // captured item
    logic                r_func;
    logic [15:0]         r_body_items;
    logic signed [15:0]  r_reps;
    logic [31:0]         r_body_size;

    // frame stack
    logic [15:0]         r_start    [MAX_LEVELS];
    logic signed [17:0]  r_last     [MAX_LEVELS];
    logic [14:0]         r_rem      [MAX_LEVELS];
    logic [31:0]         r_bsize    [MAX_LEVELS];
    logic [31:0]         r_off      [MAX_LEVELS];

    logic [LVL_W-1:0]    w_top, w_push;
    logic                w_in_loop, w_full, w_reps_bad, w_hit;
    logic [14:0]         w_rem_dec;
    logic signed [17:0]  w_cur_x, w_next_x;
    logic signed [16:0]  w_bumped;
    logic [31:0]         w_top_off;
    logic                w_do_push, w_do_restart;
    logic [31:0]         n_offset;
    logic [1:0]          n_error;

    // top frame view
    assign w_top     = LVL_W'(r_depth - DEPTH_W'(1));
    assign w_push    = LVL_W'(r_depth);
    assign w_in_loop = (r_depth != '0);
    assign w_full    = (r_depth == DEPTH_W'(MAX_LEVELS));
    assign w_top_off = w_in_loop ? r_off[w_top] : 32'd0;
    assign w_cur_x   = 18'(r_cur);
    assign w_next_x  = w_cur_x + 18'sd1;
    assign w_bumped  = bump(r_cur);
    assign w_hit     = w_in_loop && (w_cur_x == r_last[w_top]);
    assign w_rem_dec = r_rem[w_top] - 15'(r_rem[w_top] != 15'd0);
    assign w_reps_bad = (r_reps <= 16'sd0);

    // only a pop of a finished level is not final
    assign o_status.final_step = (r_func == FUNC_ENTER) || !(w_hit && (w_rem_dec == 15'd0));

    // outcome of the final step
    always_comb begin
        n_cur        = r_cur;
        n_depth      = r_depth;
        n_offset     = w_top_off;
        n_error      = ERR_NONE;
        w_do_push    = 1'b0;
        w_do_restart = 1'b0;
        if (r_func == FUNC_ENTER) begin
            if (w_full) begin
                n_error = ERR_DEPTH;
            end else if (w_reps_bad) begin
                n_error = ERR_REPS;
            end else begin
                w_do_push = 1'b1;
                n_cur     = w_bumped;
                n_depth   = r_depth + DEPTH_W'(1);
                n_offset  = 32'd0;
            end
        end else if (w_hit) begin
            w_do_restart = 1'b1;
            n_cur        = $signed({1'b0, r_start[w_top]});
            n_offset     = r_off[w_top] + r_bsize[w_top];
        end else if (r_cyclic) begin
            n_cur = (w_next_x >= $signed({2'b00, r_item_count})) ? 17'sd0 : 17'(w_next_x);
        end else begin
            n_cur = w_bumped;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= 16'd1;
            r_cyclic     <= 1'b0;
            r_cur        <= ITEM_RESET;
            r_depth      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ITEM_COUNT: r_item_count <= i_cfg_data;
                    CFG_CYCLIC:     r_cyclic     <= i_cfg_data[0];
                    default:        ;
                endcase
            end
            if (i_cmd.step) begin
                r_depth <= r_depth - DEPTH_W'(1);
            end else if (i_cmd.commit) begin
                r_cur   <= n_cur;
                r_depth <= n_depth;
            end
        end
    end

    // item capture, frame stack and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func       <= i_func;
            r_body_items <= i_body_items;
            r_reps       <= i_repetitions;
            r_body_size  <= i_body_size;
        end
        if (i_cmd.commit) begin
            if (w_do_push) begin
                r_start[w_push] <= w_bumped[15:0];
                r_last[w_push]  <= w_cur_x + $signed({2'b00, r_body_items});
                r_rem[w_push]   <= r_reps[14:0];
                r_bsize[w_push] <= r_body_size;
                r_off[w_push]   <= 32'd0;
            end
            if (w_do_restart) begin
                r_rem[w_top] <= w_rem_dec;
                r_off[w_top] <= n_offset;
            end
            o_item_index <= n_cur[15:0];
            o_offset     <= n_offset;
            o_error      <= n_error;
        end
    end

endmodule

`default_nettype wire

FILE: bench/nested_loop_item_sequencer_test.sv
// ----------------------------------------------------------------------------
// nested_loop_item_sequencer_test: self-checking bench for the loop sequencer
// Drives enter/next items through the valid/ready ports and compares every
// result item against a cycle-free model of the loop stack. The run covers
// a short scripted part (errors, a wrapping offset, deep nesting and its unwind)
// and then random loop-shaped traffic over several list settings.
// ----------------------------------------------------------------------------
module nested_loop_item_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nls_pkg::*;

    localparam int LEVELS   = 8;
    localparam int TOP_IDX  = 65535;

    typedef struct packed {
        logic               func;
        logic [15:0]        body;
        logic signed [15:0] reps;
        logic [31:0]        size;
    } t_seq_item;

    typedef struct packed {
        logic [15:0] idx;
        logic [31:0] off;
        logic [1:0]  err;
    } t_seq_result;

    // one scripted item; typed rows carry their own expected result
    typedef struct packed {
        t_seq_item   it;
        bit          typed;
        t_seq_result want;
    } t_script_row;

    // DUT ports
    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index   = CFG_ITEM_COUNT;
    logic [15:0]        i_cfg_data    = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic               i_func        = FUNC_NEXT;
    logic [15:0]        i_body_items  = '0;
    logic signed [15:0] i_repetitions = '0;
    logic [31:0]        i_body_size   = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [15:0]        o_item_index;
    logic [31:0]        o_offset;
    logic [1:0]         o_error;

    // loop stack model state and list settings
    int          cur_item = -1;
    int          nest_depth = 0;
    int          fr_start [LEVELS];
    int          fr_last  [LEVELS];
    int          fr_reps  [LEVELS];
    logic [31:0] fr_step  [LEVELS];
    logic [31:0] fr_off   [LEVELS];
    logic [15:0] cfg_count = 16'd1;
    bit          cfg_cyclic = 1'b0;

    t_seq_result pending_results[$];
    int          mismatches = 0;
    int          in_idle_pct = 38;
    int          out_idle_pct = 79;

    // scripted items: reset/error cases, a wrapping offset, full nesting,
    // then the unwind of all levels in one item and loops ending behind
    // and ahead of the index
    t_script_row script [31] = '{
        '{'{FUNC_ENTER, 16'd0, 16'sd0, 32'd0}, 1'b1, '{16'hffff, 32'd0, ERR_REPS}},
        '{'{FUNC_ENTER, 16'hffff, 16'sh8000, 32'hffff_ffff}, 1'b1,
          '{16'hffff, 32'd0, ERR_REPS}},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b1, '{16'd0, 32'd0, ERR_NONE}},
        '{'{FUNC_ENTER, 16'd2, 16'sd3, 32'hffff_ffff}, 1'b1, '{16'd1, 32'd0, ERR_NONE}},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        // eight levels that all end on the same item
        '{'{FUNC_ENTER, 16'd10, 16'sd1, 32'h0000_0010}, 1'b0, '0},
        '{'{FUNC_ENTER, 16'd9, 16'sd1, 32'h0000_0200}, 1'b0, '0},
        '{'{FUNC_ENTER, 16'd8, 16'sd1, 32'h0000_3000}, 1'b0, '0},
        '{'{FUNC_ENTER, 16'd7, 16'sd1, 32'h0004_0000}, 1'b0, '0},
        '{'{FUNC_ENTER, 16'd6, 16'sd1, 32'h0050_0000}, 1'b0, '0},
        '{'{FUNC_ENTER, 16'd5, 16'sd1, 32'h0600_0000}, 1'b0, '0},
        '{'{FUNC_ENTER, 16'd4, 16'sd1, 32'h7000_0000}, 1'b0, '0},
        '{'{FUNC_ENTER, 16'd3, 16'sd2, 32'h8000_0001}, 1'b0, '0},
        '{'{FUNC_ENTER, 16'hffff, 16'sh7fff, 32'hffff_ffff}, 1'b1,
          '{16'd11, 32'd0, ERR_DEPTH}},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        // unwind all levels, then a loop ending behind the index and one ahead
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_ENTER, 16'd0, 16'sd2, 32'd7}, 1'b0, '0},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_ENTER, 16'd5, 16'sd1, 32'h1234}, 1'b0, '0},
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b0, '0},
        // cyclic mode with an empty list
        '{'{FUNC_NEXT, 16'd0, 16'sd0, 32'd0}, 1'b1, '{16'd0, 32'd0, ERR_NONE}}
    };

    nested_loop_item_sequencer #(
        .MAX_LEVELS(LEVELS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_body_items (i_body_items),
        .i_repetitions(i_repetitions),
        .i_body_size  (i_body_size),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_item_index (o_item_index),
        .o_offset     (o_offset),
        .o_error      (o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

    // index step with saturation at the top
    function automatic int sat_inc(int v);
        return (v < TOP_IDX) ? v + 1 : TOP_IDX;
    endfunction

    // apply one item to the loop stack model, return the result it gives
    function automatic t_seq_result advance_index(t_seq_item it);
        t_seq_result r;
        int          lv;
        bit          restarted;
        r.err = ERR_NONE;
        restarted = 1'b0;
        if (it.func == FUNC_ENTER) begin
            if (nest_depth >= LEVELS) begin
                r.err = ERR_DEPTH;
            end else if ($signed(it.reps) <= 0) begin
                r.err = ERR_REPS;
            end else begin
                lv = nest_depth;
                fr_start[lv] = sat_inc(cur_item);
                fr_last[lv]  = cur_item + int'(it.body);
                fr_reps[lv]  = int'($signed(it.reps));
                fr_step[lv]  = it.size;
                fr_off[lv]   = '0;
                nest_depth   = lv + 1;
                cur_item     = sat_inc(cur_item);
            end
        end else begin
            // pop finished levels; the first unfinished one restarts its body
            while (!restarted && nest_depth > 0 && cur_item == fr_last[nest_depth - 1]) begin
                lv = nest_depth - 1;
                if (fr_reps[lv] > 0) fr_reps[lv]--;
                if (fr_reps[lv] > 0) begin
                    cur_item   = fr_start[lv];
                    fr_off[lv] = fr_off[lv] + fr_step[lv];
                    restarted  = 1'b1;
                end else begin
                    nest_depth--;
                end
            end
            if (!restarted) begin
                if (cfg_cyclic)
                    cur_item = (cur_item + 1 >= int'(cfg_count)) ? 0 : cur_item + 1;
                else
                    cur_item = sat_inc(cur_item);
            end
        end
        r.idx = cur_item[15:0];
        r.off = (nest_depth == 0) ? 32'd0 : fr_off[nest_depth - 1];
        return r;
    endfunction

    // present one item, wait for its accept, then record what it should yield
    task automatic issue_item(t_seq_item it, bit typed, t_seq_result want);
        t_seq_result p;
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_func        <= it.func;
        i_body_items  <= it.body;
        i_repetitions <= it.reps;
        i_body_size   <= it.size;
        do @(posedge i_clk); while (!o_in_ready);
        p = advance_index(it);
        pending_results.push_back(typed ? want : p);
    endtask

    // drop valid and wait until every result item is back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // write both list registers; only called while the block is idle
    task automatic program_list(logic [15:0] count, bit cyc);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ITEM_COUNT;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_count = count;
        i_cfg_index <= CFG_CYCLIC;
        i_cfg_data  <= {15'($urandom), cyc};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_cyclic = cyc;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic play_script(int lo, int hi);
        for (int k = lo; k <= hi; k++)
            issue_item(script[k].it, script[k].typed, script[k].want);
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // compare each accepted result item with the oldest expectation
    always @(posedge i_clk) begin
        t_seq_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: index %0d", o_item_index);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_item_index !== want.idx) begin
                    $error("item_index: expected %0d, got %0d", want.idx, o_item_index);
                    mismatches++;
                end
                if (o_offset !== want.off) begin
                    $error("offset: expected %0h, got %0h", want.off, o_offset);
                    mismatches++;
                end
                if (o_error !== want.err) begin
                    $error("error: expected %0d, got %0d", want.err, o_error);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_seq_item   it;
        int          base_depth;
        int          lim;
        int          room;
        int          roll;
        int          guard;
        logic [15:0] cnt;
        bit          cyc;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // scripted part: nesting, its unwind and loops around the index
        play_script(0, 29);
        settle();
        program_list(16'd0, 1'b1);
        play_script(30, 30);
        // loops opened by the script are left to the random part
        base_depth = nest_depth;

        // random loop traffic under three stall patterns
        for (int m = 0; m < 3; m++) begin
            case (m)
                0: begin in_idle_pct = 38; out_idle_pct = 79; end
                1: begin in_idle_pct = 79; out_idle_pct = 38; end
                default: begin in_idle_pct = 0; out_idle_pct = 0; end
            endcase
            for (int b = 0; b < 3; b++) begin
                // finish open loops so new settings cannot strand them
                guard = 0;
                while (nest_depth > base_depth && guard < 20000) begin
                    it.func = FUNC_NEXT;
                    it.body = 16'($urandom);
                    it.reps = 16'($urandom);
                    it.size = $urandom;
                    issue_item(it, 1'b0, '0);
                    guard++;
                end
                settle();
                if (m == 0 && b == 0) begin
                    cnt = 16'hffff;
                    cyc = 1'b1;
                end else begin
                    roll = $urandom_range(0, 99);
                    cnt = (roll < 10) ? 16'd1 : (roll < 20) ? 16'hffff :
                          (roll < 25) ? 16'd0 : 16'($urandom_range(2, 40));
                    cyc = 1'($urandom_range(0, 1));
                end
                program_list(cnt, cyc);

                repeat (60) begin
                    // room left before the list end or the enclosing loop's last item;
                    // a loop whose last item is behind the index bounds nothing
                    lim = cfg_cyclic ? int'(cfg_count) - 1 : TOP_IDX;
                    if (nest_depth > 0 && fr_last[nest_depth - 1] < lim &&
                        fr_last[nest_depth - 1] >= cur_item)
                        lim = fr_last[nest_depth - 1];
                    room = lim - cur_item;
                    roll = $urandom_range(0, 99);
                    it.func = FUNC_NEXT;
                    it.body = 16'($urandom);
                    it.reps = 16'($urandom);
                    it.size = $urandom;
                    if (roll < 6) begin
                        // bad repeat count: zero or negative
                        it.func = FUNC_ENTER;
                        it.reps = ($urandom_range(0, 3) == 0) ? 16'sd0 : {1'b1, 15'($urandom)};
                    end else if (roll < 45 && (room >= 1 || nest_depth >= LEVELS)) begin
                        it.func = FUNC_ENTER;
                        if (nest_depth < LEVELS) begin
                            it.body = 16'($urandom_range(1, (room < 12) ? room : 12));
                            it.reps = 16'($urandom_range(1, 3));
                        end
                    end
                    issue_item(it, 1'b0, '0);
                end
            end
        end

        settle();
        repeat (LEVELS + 6) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
